// ----- hdl/pooling_buffer_address_sequencer_defines.svh -----
// Assertion macros for the pooling buffer address sequencer.
`ifndef POOLING_BUFFER_ADDRESS_SEQUENCER_DEFINES_SVH
`define POOLING_BUFFER_ADDRESS_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PBAS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PBAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PBAS_ASSERT(lbl, ante, cons, msg)
`define PBAS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/pbas_pkg.sv -----
// Shared widths, codes and types of the pooling buffer address sequencer.
package pbas_pkg;

  localparam int BUS_WIDTH_DEF = 16;

  localparam int ROW_LEN_W = 13;
  localparam int CH_CNT_W  = 11;
  localparam int CHAN_W    = 10;
  localparam int CHUNK_W   = 8;
  localparam int SLOT_W    = 3;
  localparam int ADDR_W    = 23;
  localparam int LEN_W     = 5;
  localparam int COUNT_W   = 22;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = ROW_LEN_W'(16);
  localparam logic [CH_CNT_W-1:0]  CH_CNT_RST  = CH_CNT_W'(1);
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;

  // input op codes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESULT = 2'd2;

  // result kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DIST = 3'b010,
    PH_SENT = 3'b100
  } phase_t;

  // read request fields for the current counter position
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [CHAN_W-1:0]  channel;
    logic [CHUNK_W-1:0] chunk;
  } rd_req_t;

  // read sequencer status
  typedef struct packed {
    logic sweeping; // distributing
    logic sent;     // all reads issued
    logic last;     // a tick now issues the final read
  } rd_stat_t;

endpackage

// ----- hdl/pooling_buffer_address_sequencer.sv -----
// Top level of the pooling buffer address sequencer.
//
// Address sequencer for a 2x2 pooling buffer. A start beat (op 0) clears the
// read counters, the result count and the finished mark and begins the read
// sweep. Each tick beat (op 1) during the sweep yields one read request for
// one chunk of one of the two rows of a channel: rows step first, then
// chunks (BUS_WIDTH elements, the row's last one shorter), then channels;
// after the last channel out_all_sent stays high until the next start. Each
// result beat (op 2) yields one write of its bit at
// (channel*row_length)/2 + chunk*BUS_WIDTH/2 + slot and is counted;
// out_finished rises once the count reaches channel_count*(row_length/2).
// Ticks outside the sweep and op 3 produce no output beat. Throughput is one
// input beat per clock while out_stall does not hold the output register; a
// beat passes the input register, then the output register, with all counter
// updates in the stage between. Each stage advances whenever the output
// register is empty or being taken, so out_stall reaches in_stall through one
// gate of logic. The write-address multiply and the expected-count multiply
// sit in front of registers, fed from the next-cycle configuration values.
// Configure only while no beat is in flight.
`include "pooling_buffer_address_sequencer_defines.svh"

module pooling_buffer_address_sequencer #(
  parameter int BUS_WIDTH = pbas_pkg::BUS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [pbas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbas_pkg::ROW_LEN_W-1:0] cfg_wdata,
  // input beats
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pbas_pkg::OP_W-1:0]      in_op,
  input  logic [pbas_pkg::CHAN_W-1:0]    in_result_channel,
  input  logic [pbas_pkg::CHUNK_W-1:0]   in_result_chunk,
  input  logic [pbas_pkg::SLOT_W-1:0]    in_result_slot,
  input  logic                           in_result_bit,
  // output beats
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [pbas_pkg::ADDR_W-1:0]    out_mem_address,
  output logic [pbas_pkg::LEN_W-1:0]     out_chunk_length,
  output logic [pbas_pkg::CHAN_W-1:0]    out_tag_channel,
  output logic [pbas_pkg::CHUNK_W-1:0]   out_tag_chunk,
  output logic                           out_write_bit,
  output logic                           out_all_sent,
  output logic                           out_finished
);

  localparam int ADDR_W  = pbas_pkg::ADDR_W;
  localparam int COUNT_W = pbas_pkg::COUNT_W;
  localparam int HALF_BW = BUS_WIDTH / 2;

  // ---------------- configuration ----------------
  logic [pbas_pkg::ROW_LEN_W-1:0] row_length_r, row_length_nxt;
  logic [pbas_pkg::CH_CNT_W-1:0]  channel_count_r, channel_count_nxt;
  logic [ADDR_W-1:0]              required_r;    // channel_count*(row_length/2)
  logic [pbas_pkg::CHAN_W-1:0]    last_ch;

  always_comb begin
    row_length_nxt    = row_length_r;
    channel_count_nxt = channel_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pbas_pkg::CFG_ROW_LENGTH:    row_length_nxt    = cfg_wdata;
        pbas_pkg::CFG_CHANNEL_COUNT: channel_count_nxt = cfg_wdata[pbas_pkg::CH_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r    <= pbas_pkg::ROW_LEN_RST;
      channel_count_r <= pbas_pkg::CH_CNT_RST;
    end else begin
      row_length_r    <= row_length_nxt;
      channel_count_r <= channel_count_nxt;
    end
  end

  // tracks the live registers in step, not behind them: computed from next values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      required_r <= ADDR_W'(pbas_pkg::CH_CNT_RST) * ADDR_W'(pbas_pkg::ROW_LEN_RST >> 1);
    end else begin
      required_r <= ADDR_W'(channel_count_nxt) * ADDR_W'(row_length_nxt >> 1);
    end
  end

  // sweep ends at channel_count-1, clamped into the tag range
  always_comb begin
    if (channel_count_r == '0) begin
      last_ch = '0;
    end else if (channel_count_r > pbas_pkg::CH_CNT_W'(2 ** pbas_pkg::CHAN_W)) begin
      last_ch = '1;
    end else begin
      last_ch = pbas_pkg::CHAN_W'(channel_count_r - 1'b1);
    end
  end

  // ---------------- stage 1: input register ----------------
  logic                            s1_valid_r;
  logic [pbas_pkg::OP_W-1:0]       s1_op_r;
  logic [pbas_pkg::CHUNK_W-1:0]    s1_chunk_r;
  logic [pbas_pkg::SLOT_W-1:0]     s1_slot_r;
  logic                            s1_bit_r;
  logic [ADDR_W-1:0]               s1_prod_r;    // result_channel * row_length
  logic                            s1_adv, s1_fire, in_fire;
  logic                            out_valid_r;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_op;
      s1_chunk_r <= in_result_chunk;
      s1_slot_r  <= in_result_slot;
      s1_bit_r   <= in_result_bit;
      s1_prod_r  <= ADDR_W'(in_result_channel) * ADDR_W'(row_length_nxt);
    end
  end

  // ---------------- stage 2: sequencing ----------------
  logic               start, tick, res;
  pbas_pkg::rd_req_t  rd_req;
  pbas_pkg::rd_stat_t rd_stat;

  always_comb begin
    start = 1'b0;
    tick  = 1'b0;
    res   = 1'b0;
    unique case (s1_op_r)
      pbas_pkg::OP_START:  start = s1_fire;
      pbas_pkg::OP_TICK:   tick  = s1_fire;
      pbas_pkg::OP_RESULT: res   = s1_fire;
      default: ;
    endcase
  end

  pbas_rd_gen #(
    .BUS_WIDTH (BUS_WIDTH)
  ) u_rd_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .tick       (tick),
    .row_length (row_length_r),
    .last_ch    (last_ch),
    .req        (rd_req),
    .stat       (rd_stat)
  );

  // result count and finished mark; count saturates
  logic [COUNT_W-1:0] written_r, written_nxt, written_inc;
  logic               done_r, done_nxt;

  always_comb begin
    written_inc = written_r + 1'b1;
    written_nxt = written_r;
    done_nxt    = done_r;
    if (start) begin
      written_nxt = '0;
      done_nxt    = 1'b0;
    end else if (res && (written_r != pbas_pkg::COUNT_MAX)) begin
      written_nxt = written_inc;
      if ({1'b0, written_inc} == required_r) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      done_r    <= 1'b0;
    end else begin
      written_r <= written_nxt;
      done_r    <= done_nxt;
    end
  end

  logic              tick_out, s1_has_res;
  logic [ADDR_W-1:0] wr_addr;

  assign tick_out   = (s1_op_r == pbas_pkg::OP_TICK) && rd_stat.sweeping;
  assign s1_has_res = tick_out || (s1_op_r == pbas_pkg::OP_RESULT);
  assign wr_addr    = (s1_prod_r >> 1) + ADDR_W'(s1_chunk_r) * ADDR_W'(HALF_BW)
                    + ADDR_W'(s1_slot_r);

  // ---------------- output register ----------------
  logic                          out_kind_r;
  logic [ADDR_W-1:0]             out_mem_address_r;
  logic [pbas_pkg::LEN_W-1:0]    out_chunk_length_r;
  logic [pbas_pkg::CHAN_W-1:0]   out_tag_channel_r;
  logic [pbas_pkg::CHUNK_W-1:0]  out_tag_chunk_r;
  logic                          out_write_bit_r;
  logic                          out_all_sent_r;
  logic                          out_finished_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r && s1_has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      out_finished_r <= done_nxt;
      if (tick_out) begin
        out_kind_r         <= pbas_pkg::KIND_READ;
        out_mem_address_r  <= rd_req.addr;
        out_chunk_length_r <= rd_req.len;
        out_tag_channel_r  <= rd_req.channel;
        out_tag_chunk_r    <= rd_req.chunk;
        out_write_bit_r    <= 1'b0;
        out_all_sent_r     <= rd_stat.sent || rd_stat.last;
      end else begin
        out_kind_r         <= pbas_pkg::KIND_WRITE;
        out_mem_address_r  <= wr_addr;
        out_chunk_length_r <= '0;
        out_tag_channel_r  <= '0;
        out_tag_chunk_r    <= '0;
        out_write_bit_r    <= s1_bit_r;
        out_all_sent_r     <= rd_stat.sent;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_mem_address  = out_mem_address_r;
  assign out_chunk_length = out_chunk_length_r;
  assign out_tag_channel  = out_tag_channel_r;
  assign out_tag_chunk    = out_tag_chunk_r;
  assign out_write_bit    = out_write_bit_r;
  assign out_all_sent     = out_all_sent_r;
  assign out_finished     = out_finished_r;

  // ---------------- assertions ----------------
  `PBAS_ASSERT_NEXT(a_res_loaded, s1_fire && s1_has_res, out_valid_r, "result beat lost")
  `PBAS_ASSERT(a_stall_has_item, in_stall, s1_valid_r, "input stalled with empty stage")
  `PBAS_ASSERT(a_write_clean, out_valid_r && (out_kind_r == pbas_pkg::KIND_WRITE), (out_chunk_length_r == '0) && (out_tag_channel_r == '0) && (out_tag_chunk_r == '0), "write beat carries read fields")

endmodule

// ----- hdl/pbas_rd_gen.sv -----
// Read request sequencer: row, chunk and channel counters with the read address.
module pbas_rd_gen #(
  parameter int BUS_WIDTH = pbas_pkg::BUS_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           tick,
  input  logic [pbas_pkg::ROW_LEN_W-1:0] row_length,
  input  logic [pbas_pkg::CHAN_W-1:0]    last_ch,
  output pbas_pkg::rd_req_t              req,
  output pbas_pkg::rd_stat_t             stat
);

  localparam int ADDR_W = pbas_pkg::ADDR_W;
  localparam int OFF_W  = $clog2((2 ** pbas_pkg::CHUNK_W) * BUS_WIDTH);
  localparam int CMP_W  = ((OFF_W > pbas_pkg::ROW_LEN_W) ? OFF_W : pbas_pkg::ROW_LEN_W) + 1;
  localparam logic [CMP_W-1:0] BW_C  = CMP_W'(BUS_WIDTH);
  localparam logic [OFF_W-1:0] BW_O  = OFF_W'(BUS_WIDTH);

  pbas_pkg::phase_t                 phase_r, phase_nxt;
  logic [pbas_pkg::CHAN_W-1:0]      channel_r, channel_nxt;
  logic [pbas_pkg::CHUNK_W-1:0]     chunk_r, chunk_nxt;
  logic                             row_r, row_nxt;
  logic [OFF_W-1:0]                 chunk_off_r, chunk_off_nxt;

  logic [CMP_W-1:0] off_ext, rl_ext, off_step, rest;
  logic             chunk_end, chan_end;

  always_comb begin
    off_ext   = CMP_W'(chunk_off_r);
    rl_ext    = CMP_W'(row_length);
    off_step  = off_ext + BW_C;
    // chunk+1 >= ceil(rl/BW) without a divide; 256 chunks at most
    chunk_end = (off_step >= rl_ext) || (chunk_r == '1);
    chan_end  = (channel_r >= last_ch);
    rest      = (rl_ext > off_ext) ? (rl_ext - off_ext) : '0;
  end

  // channel base from the live row length, so a reconfigured shape applies at once
  always_comb begin
    req.addr    = ADDR_W'(channel_r) * (ADDR_W'(row_length) << 1)
                + (row_r ? ADDR_W'(row_length) : '0) + ADDR_W'(chunk_off_r);
    req.len     = (rest < BW_C) ? rest[pbas_pkg::LEN_W-1:0] : BW_C[pbas_pkg::LEN_W-1:0];
    req.channel = channel_r;
    req.chunk   = chunk_r;
    stat.sweeping = (phase_r == pbas_pkg::PH_DIST);
    stat.sent     = (phase_r == pbas_pkg::PH_SENT);
    stat.last     = row_r && chunk_end && chan_end;
  end

  always_comb begin
    phase_nxt     = phase_r;
    channel_nxt   = channel_r;
    chunk_nxt     = chunk_r;
    row_nxt       = row_r;
    chunk_off_nxt = chunk_off_r;
    if (start) begin
      phase_nxt     = pbas_pkg::PH_DIST;
      channel_nxt   = '0;
      chunk_nxt     = '0;
      row_nxt       = 1'b0;
      chunk_off_nxt = '0;
    end else begin
      unique case (phase_r)
        pbas_pkg::PH_DIST: begin
          if (tick) begin
            row_nxt = ~row_r;
            if (row_r) begin
              if (chunk_end) begin
                chunk_nxt     = '0;
                chunk_off_nxt = '0;
                if (chan_end) begin
                  channel_nxt   = '0;
                  phase_nxt     = pbas_pkg::PH_SENT;
                end else begin
                  channel_nxt   = channel_r + 1'b1;
                end
              end else begin
                chunk_nxt     = chunk_r + 1'b1;
                chunk_off_nxt = chunk_off_r + BW_O;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pbas_pkg::PH_IDLE;
      channel_r   <= '0;
      chunk_r     <= '0;
      row_r       <= 1'b0;
      chunk_off_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      channel_r   <= channel_nxt;
      chunk_r     <= chunk_nxt;
      row_r       <= row_nxt;
      chunk_off_r <= chunk_off_nxt;
    end
  end

endmodule
